### rtl/core/ubxp_pkg.sv
package ubxp_pkg;

   localparam logic [7:0] SYNC_FIRST_BYTE  = 8'hB5;
   localparam logic [7:0] SYNC_SECOND_BYTE = 8'h62;
   localparam logic [7:0] CLASS_ACK        = 8'h05;
   localparam logic [7:0] ID_ACK_ACK       = 8'h01;
   localparam logic [7:0] ID_ACK_NAK       = 8'h00;
   localparam logic [7:0] CLASS_MON        = 8'h0A;
   localparam logic [7:0] ID_MON_VER       = 8'h04;
   localparam logic [15:0] MIN_ACK_LENGTH  = 16'd2;
   localparam logic [15:0] MIN_VER_LENGTH  = 16'd40;

   localparam logic [1:0] KIND_OTHER   = 2'd0;
   localparam logic [1:0] KIND_ACK     = 2'd1;
   localparam logic [1:0] KIND_NAK     = 2'd2;
   localparam logic [1:0] KIND_VERSION = 2'd3;

   typedef struct packed {
      logic [7:0]  msg_class;
      logic [7:0]  msg_id;
      logic [15:0] payload_length;
      logic        checksum_ok;
      logic [1:0]  frame_kind;
      logic [7:0]  acked_class;
      logic [7:0]  acked_id;
   } result_type;

endpackage

### rtl/core/ubxp_core.sv
module ubxp_core
   import ubxp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_accept,
   input  logic [7:0] byte_in,
   output logic       result_valid,
   output result_type result
);

   localparam logic [3:0] PH_SYNC1   = 4'd0;
   localparam logic [3:0] PH_SYNC2   = 4'd1;
   localparam logic [3:0] PH_CLASS   = 4'd2;
   localparam logic [3:0] PH_ID      = 4'd3;
   localparam logic [3:0] PH_LEN_LO  = 4'd4;
   localparam logic [3:0] PH_LEN_HI  = 4'd5;
   localparam logic [3:0] PH_PAYLOAD = 4'd6;
   localparam logic [3:0] PH_CK_A    = 4'd7;
   localparam logic [3:0] PH_CK_B    = 4'd8;

   logic [3:0]  phase_ff, phase_in;
   logic [7:0]  class_ff, class_in;
   logic [7:0]  id_ff, id_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  sum_a_ff, sum_a_in;
   logic [7:0]  sum_b_ff, sum_b_in;
   logic [7:0]  first_ff, first_in;
   logic [7:0]  second_ff, second_in;
   logic [7:0]  ck_a_ff, ck_a_in;

   logic [7:0]  acc_a;
   logic [7:0]  acc_b;
   logic [15:0] count_inc;
   logic [15:0] length_full;
   logic        sums_match;

   // Fletcher-8 step on the current byte, used by every summed phase after the class byte.
   assign acc_a       = sum_a_ff + byte_in;
   assign acc_b       = sum_b_ff + acc_a;
   assign count_inc   = (count_ff != 16'hFFFF) ? count_ff + 16'd1 : count_ff;
   assign length_full = {byte_in, length_ff[7:0]};
   assign sums_match  = (ck_a_ff == sum_a_ff) && (byte_in == sum_b_ff);

   always_comb begin
      phase_in  = phase_ff;
      class_in  = class_ff;
      id_in     = id_ff;
      length_in = length_ff;
      count_in  = count_ff;
      sum_a_in  = sum_a_ff;
      sum_b_in  = sum_b_ff;
      first_in  = first_ff;
      second_in = second_ff;
      ck_a_in   = ck_a_ff;
      result_valid = 1'b0;

      result.msg_class      = class_ff;
      result.msg_id         = id_ff;
      result.payload_length = length_ff;
      result.checksum_ok    = sums_match;
      result.frame_kind     = KIND_OTHER;
      result.acked_class    = 8'd0;
      result.acked_id       = 8'd0;
      if (sums_match) begin
         if (class_ff == CLASS_ACK && (id_ff == ID_ACK_ACK || id_ff == ID_ACK_NAK)
             && length_ff >= MIN_ACK_LENGTH) begin
            result.frame_kind  = (id_ff == ID_ACK_ACK) ? KIND_ACK : KIND_NAK;
            result.acked_class = first_ff;
            result.acked_id    = second_ff;
         end else if (class_ff == CLASS_MON && id_ff == ID_MON_VER
                      && length_ff >= MIN_VER_LENGTH) begin
            result.frame_kind = KIND_VERSION;
         end
      end

      if (byte_accept) begin
         unique case (phase_ff)
            PH_SYNC2: begin
               if (byte_in == SYNC_SECOND_BYTE) begin
                  phase_in = PH_CLASS;
               end else begin
                  phase_in  = PH_SYNC1;
                  length_in = 16'd0;
                  count_in  = 16'd0;
                  sum_a_in  = 8'd0;
                  sum_b_in  = 8'd0;
               end
            end
            PH_CLASS: begin
               // The sums restart with the class byte.
               class_in = byte_in;
               sum_a_in = byte_in;
               sum_b_in = byte_in;
               phase_in = PH_ID;
            end
            PH_ID: begin
               id_in    = byte_in;
               sum_a_in = acc_a;
               sum_b_in = acc_b;
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               length_in = {8'd0, byte_in};
               sum_a_in  = acc_a;
               sum_b_in  = acc_b;
               phase_in  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               length_in = length_full;
               sum_a_in  = acc_a;
               sum_b_in  = acc_b;
               count_in  = 16'd0;
               first_in  = 8'd0;
               second_in = 8'd0;
               phase_in  = (length_full == 16'd0) ? PH_CK_A : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               if (count_ff == 16'd0) begin
                  first_in = byte_in;
               end else if (count_ff == 16'd1) begin
                  second_in = byte_in;
               end
               sum_a_in = acc_a;
               sum_b_in = acc_b;
               count_in = count_inc;
               if (count_inc >= length_ff) begin
                  phase_in = PH_CK_A;
               end
            end
            PH_CK_A: begin
               ck_a_in  = byte_in;
               phase_in = PH_CK_B;
            end
            PH_CK_B: begin
               result_valid = 1'b1;
               phase_in  = PH_SYNC1;
               length_in = 16'd0;
               count_in  = 16'd0;
               sum_a_in  = 8'd0;
               sum_b_in  = 8'd0;
            end
            default: begin
               // Hunting, and any code without a meaning behaves as hunting.
               phase_in = (byte_in == SYNC_FIRST_BYTE) ? PH_SYNC2 : PH_SYNC1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SYNC1;
         class_ff  <= 8'd0;
         id_ff     <= 8'd0;
         length_ff <= 16'd0;
         count_ff  <= 16'd0;
         sum_a_ff  <= 8'd0;
         sum_b_ff  <= 8'd0;
         first_ff  <= 8'd0;
         second_ff <= 8'd0;
         ck_a_ff   <= 8'd0;
      end else begin
         phase_ff  <= phase_in;
         class_ff  <= class_in;
         id_ff     <= id_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         sum_a_ff  <= sum_a_in;
         sum_b_ff  <= sum_b_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         ck_a_ff   <= ck_a_in;
      end
   end

endmodule

### rtl/core/ubx_frame_parser.sv
// Binary frame parser for a received serial byte stream.
//
// The req channel carries one received byte per transaction. The block hunts
// for the two sync bytes, collects class, id and the little-endian length,
// runs a Fletcher-8 sum over class through payload, and compares it with the
// two checksum bytes at the end of the frame. Bytes that do not complete a
// frame produce no rsp transaction.
//
// When the second checksum byte is accepted, one rsp transaction follows in
// the next cycle with class, id, length, the checksum flag and, for good
// frames, the frame kind (acknowledge, negative acknowledge or version
// report) with the acknowledged class and id where they apply.
//
// Throughput is one byte per cycle, and rsp_valid rises in the cycle after the
// second checksum byte is accepted. While the registered result waits on a
// stalled receiver (rsp_valid high, rsp_ready low) req_ready is low; it
// returns high in the same cycle the receiver takes the result.
//
// Synchronous reset puts the parser back to hunting for the first sync byte,
// clears sums, length and captured bytes, and drops any pending result.
module ubx_frame_parser
   import ubxp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_msg_class,
   output logic [7:0]  rsp_msg_id,
   output logic [15:0] rsp_payload_length,
   output logic        rsp_checksum_ok,
   output logic [1:0]  rsp_frame_kind,
   output logic [7:0]  rsp_acked_class,
   output logic [7:0]  rsp_acked_id
);

   logic       req_accept;
   logic       core_valid;
   result_type core_result;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   // A new byte may enter whenever the output register is empty or being drained.
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   ubxp_core u_core (
      .clock        (clock),
      .reset        (reset),
      .byte_accept  (req_accept),
      .byte_in      (req_byte_in),
      .result_valid (core_valid),
      .result       (core_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (core_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The payload register needs no reset; it is only read while valid is high.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_msg_class      = rsp_data_ff.msg_class;
   assign rsp_msg_id         = rsp_data_ff.msg_id;
   assign rsp_payload_length = rsp_data_ff.payload_length;
   assign rsp_checksum_ok    = rsp_data_ff.checksum_ok;
   assign rsp_frame_kind     = rsp_data_ff.frame_kind;
   assign rsp_acked_class    = rsp_data_ff.acked_class;
   assign rsp_acked_id       = rsp_data_ff.acked_id;

   // A stalled result must block the byte stream, or a result could be lost.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("byte accepted while a result was stalled");

   // Only frames with a good checksum are classified.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_kind != KIND_OTHER) |-> rsp_checksum_ok)
      else $error("frame kind reported for a bad checksum");

   // Acknowledge kinds carry the matching class, id and a long enough payload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_frame_kind == KIND_ACK || rsp_frame_kind == KIND_NAK)) |->
      (rsp_msg_class == CLASS_ACK && rsp_payload_length >= MIN_ACK_LENGTH &&
       rsp_msg_id == ((rsp_frame_kind == KIND_ACK) ? ID_ACK_ACK : ID_ACK_NAK)))
      else $error("acknowledge kind does not match the frame header");

   // Version reports carry their class, id and minimum length.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_kind == KIND_VERSION) |->
      (rsp_msg_class == CLASS_MON && rsp_msg_id == ID_MON_VER &&
       rsp_payload_length >= MIN_VER_LENGTH))
      else $error("version kind does not match the frame header");

endmodule

### test/ubx_frame_parser_checker.sv
module ubx_frame_parser_checker
   import ubxp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_byte_in,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_msg_class,
   input  logic [7:0]  rsp_msg_id,
   input  logic [15:0] rsp_payload_length,
   input  logic        rsp_checksum_ok,
   input  logic [1:0]  rsp_frame_kind,
   input  logic [7:0]  rsp_acked_class,
   input  logic [7:0]  rsp_acked_id,
   output int          fail_count,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [3:0] {
      HUNT_SYNC1,
      HUNT_SYNC2,
      GET_CLASS,
      GET_ID,
      GET_LEN_LO,
      GET_LEN_HI,
      GET_PAYLOAD,
      GET_CK_A,
      GET_CK_B
   } parse_phase_type;

   parse_phase_type rx_phase;
   logic [7:0]   hdr_class;
   logic [7:0]   hdr_id;
   logic [15:0]  hdr_length;
   logic [15:0]  payload_seen;
   logic [7:0]   fl_a;
   logic [7:0]   fl_b;
   logic [7:0]   pay_first;
   logic [7:0]   pay_second;
   logic [7:0]   ck_a_rx;

   result_type   frames_due[$];
   result_type   oldest;

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   task automatic restart_hunt();
      rx_phase     = HUNT_SYNC1;
      hdr_length   = '0;
      payload_seen = '0;
      fl_a         = '0;
      fl_b         = '0;
   endtask

   task automatic fletcher_add(input logic [7:0] b);
      fl_a = fl_a + b;
      fl_b = fl_b + fl_a;
   endtask

   // Advances the frame parser by one received byte and queues the result
   // when the second checksum byte closes a frame.
   task automatic parse_byte(input logic [7:0] b);
      result_type done;
      logic       good;
      case (rx_phase)
         HUNT_SYNC2: begin
            if (b == SYNC_SECOND_BYTE) rx_phase = GET_CLASS;
            else restart_hunt();
         end
         GET_CLASS: begin
            hdr_class = b;
            fl_a      = '0;
            fl_b      = '0;
            fletcher_add(b);
            rx_phase  = GET_ID;
         end
         GET_ID: begin
            hdr_id = b;
            fletcher_add(b);
            rx_phase = GET_LEN_LO;
         end
         GET_LEN_LO: begin
            hdr_length = {8'h00, b};
            fletcher_add(b);
            rx_phase = GET_LEN_HI;
         end
         GET_LEN_HI: begin
            hdr_length[15:8] = b;
            fletcher_add(b);
            payload_seen = '0;
            pay_first    = '0;
            pay_second   = '0;
            rx_phase = (hdr_length == 16'd0) ? GET_CK_A : GET_PAYLOAD;
         end
         GET_PAYLOAD: begin
            if (payload_seen == 16'd0) pay_first = b;
            else if (payload_seen == 16'd1) pay_second = b;
            fletcher_add(b);
            if (payload_seen != 16'hFFFF) payload_seen = payload_seen + 16'd1;
            if (payload_seen >= hdr_length) rx_phase = GET_CK_A;
         end
         GET_CK_A: begin
            ck_a_rx  = b;
            rx_phase = GET_CK_B;
         end
         GET_CK_B: begin
            good = (ck_a_rx == fl_a) && (b == fl_b);
            done = '0;
            done.msg_class      = hdr_class;
            done.msg_id         = hdr_id;
            done.payload_length = hdr_length;
            done.checksum_ok    = good;
            done.frame_kind     = KIND_OTHER;
            if (good && hdr_class == CLASS_ACK &&
                (hdr_id == ID_ACK_ACK || hdr_id == ID_ACK_NAK) &&
                hdr_length >= MIN_ACK_LENGTH) begin
               done.frame_kind  = (hdr_id == ID_ACK_ACK) ? KIND_ACK : KIND_NAK;
               done.acked_class = pay_first;
               done.acked_id    = pay_second;
            end else if (good && hdr_class == CLASS_MON && hdr_id == ID_MON_VER &&
                         hdr_length >= MIN_VER_LENGTH) begin
               done.frame_kind = KIND_VERSION;
            end
            frames_due = {frames_due, done};
            restart_hunt();
         end
         default: begin
            rx_phase = (b == SYNC_FIRST_BYTE) ? HUNT_SYNC2 : HUNT_SYNC1;
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restart_hunt();
         hdr_class  = '0;
         hdr_id     = '0;
         pay_first  = '0;
         pay_second = '0;
         ck_a_rx    = '0;
         frames_due.delete();
      end else begin
         // The result leaving now always belongs to an earlier byte, so it is
         // compared before this edge's byte is parsed.
         if (rsp_valid && rsp_ready) begin
            if (frames_due.size() == 0) begin
               fail_count++;
               $display("%0t: result with no frame pending, expected none,",
                        $time, " actual class %0h id %0h", rsp_msg_class, rsp_msg_id);
            end else begin
               oldest = frames_due.pop_front();
               check_field("msg_class", 16'(oldest.msg_class), 16'(rsp_msg_class));
               check_field("msg_id", 16'(oldest.msg_id), 16'(rsp_msg_id));
               check_field("payload_length", oldest.payload_length, rsp_payload_length);
               check_field("checksum_ok", 16'(oldest.checksum_ok), 16'(rsp_checksum_ok));
               check_field("frame_kind", 16'(oldest.frame_kind), 16'(rsp_frame_kind));
               check_field("acked_class", 16'(oldest.acked_class), 16'(rsp_acked_class));
               check_field("acked_id", 16'(oldest.acked_id), 16'(rsp_acked_id));
            end
         end
         if (req_valid && req_ready) parse_byte(req_byte_in);
      end
      outstanding <= frames_due.size();
   end

endmodule

### test/ubx_frame_parser_tb.sv
module ubx_frame_parser_tb;
   import ubxp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Ways a frame can be damaged on its way in. A damaged tail replaces both
   // checksum bytes with noise, as if the end of the frame had been lost.
   localparam int INTACT    = 0;
   localparam int BAD_CK_A  = 1;
   localparam int BAD_CK_B  = 2;
   localparam int BAD_TAIL  = 3;

   // Bytes of random stimulus per idling phase.
   localparam int PHASE_BYTES = 350;

   // A run is about 1800 bytes, at most a few hundred of them in the one long
   // frame; even with heavy idling and stalling the limit leaves a wide margin.
   localparam longint CYCLE_LIMIT = 100_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_byte_in = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_msg_class;
   logic [7:0]  rsp_msg_id;
   logic [15:0] rsp_payload_length;
   logic        rsp_checksum_ok;
   logic [1:0]  rsp_frame_kind;
   logic [7:0]  rsp_acked_class;
   logic [7:0]  rsp_acked_id;

   int     fail_count;
   int     outstanding;
   int     send_idle_pct = 0;
   int     recv_stall_pct = 0;
   int     bytes_sent = 0;
   longint cycle_count = 0;

   always #5 clock = ~clock;

   ubx_frame_parser DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_byte_in        (req_byte_in),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_msg_class      (rsp_msg_class),
      .rsp_msg_id         (rsp_msg_id),
      .rsp_payload_length (rsp_payload_length),
      .rsp_checksum_ok    (rsp_checksum_ok),
      .rsp_frame_kind     (rsp_frame_kind),
      .rsp_acked_class    (rsp_acked_class),
      .rsp_acked_id       (rsp_acked_id)
   );

   // The checker watches both channels, predicts every frame result from the
   // accepted bytes and compares. It reports how many checks failed and how
   // many results are still owed.
   ubx_frame_parser_checker frame_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_byte_in        (req_byte_in),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_msg_class      (rsp_msg_class),
      .rsp_msg_id         (rsp_msg_id),
      .rsp_payload_length (rsp_payload_length),
      .rsp_checksum_ok    (rsp_checksum_ok),
      .rsp_frame_kind     (rsp_frame_kind),
      .rsp_acked_class    (rsp_acked_class),
      .rsp_acked_id       (rsp_acked_id),
      .fail_count         (fail_count),
      .outstanding        (outstanding)
   );

   // The receiver decides each cycle whether it will take a result. With a
   // zero stall rate it is always ready, which gives the stretches where the
   // result register never backs up into the byte channel.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog: a hung handshake or a lost result ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ubx_frame_parser_tb: errors");
         $finish;
      end
   end

   // Sends one byte as a transaction. Before raising valid, the sender may sit
   // idle for a geometric number of cycles, so that the share of idle cycles
   // follows the current idle rate and gaps land in every parser phase. When
   // there is no gap, valid simply stays high into the next transaction.
   task automatic send_byte(input logic [7:0] b);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_byte_in <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   // Sends a complete frame: both sync bytes, the header, a payload whose
   // first two bytes are given (the rest random) and the two checksum bytes.
   // The Fletcher sums are computed here only to build well-formed frames;
   // the damage argument then spoils one or both of them on purpose.
   task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                             input logic [15:0] len, input logic [7:0] p0,
                             input logic [7:0] p1, input int damage);
      logic [7:0] sum_a;
      logic [7:0] sum_b;
      logic [7:0] b;
      logic [7:0] head [4];
      int         i;
      sum_a   = '0;
      sum_b   = '0;
      head[0] = cls;
      head[1] = id;
      head[2] = len[7:0];
      head[3] = len[15:8];
      send_byte(SYNC_FIRST_BYTE);
      send_byte(SYNC_SECOND_BYTE);
      for (i = 0; i < 4 + int'(len); i++) begin
         if (i < 4) b = head[i];
         else if (i == 4) b = p0;
         else if (i == 5) b = p1;
         else b = 8'($urandom_range(255));
         sum_a = sum_a + b;
         sum_b = sum_b + sum_a;
         send_byte(b);
      end
      case (damage)
         BAD_CK_A: sum_a = sum_a ^ 8'($urandom_range(255, 1));
         BAD_CK_B: sum_b = sum_b ^ 8'($urandom_range(255, 1));
         BAD_TAIL: begin
            sum_a = 8'($urandom_range(255));
            sum_b = 8'($urandom_range(255));
         end
         default: ;
      endcase
      send_byte(sum_a);
      send_byte(sum_b);
   endtask

   // One random frame. Most frames are well formed so that the parser gets
   // through every phase; the classes lean toward the acknowledge and version
   // report kinds, including lengths just below and at their minimums, and
   // toward near misses on class or id.
   task automatic random_frame();
      logic [7:0]  cls;
      logic [7:0]  id;
      logic [15:0] len;
      int          pick;
      int          hurt;
      int          damage;
      pick = $urandom_range(99);
      hurt = $urandom_range(99);
      if (pick < 25) begin
         cls = CLASS_ACK;
         id  = $urandom_range(1) ? ID_ACK_ACK : ID_ACK_NAK;
         len = 16'($urandom_range(4));
      end else if (pick < 40) begin
         cls = CLASS_MON;
         id  = ID_MON_VER;
         len = 16'($urandom_range(44, 38));
      end else if (pick < 55) begin
         cls = $urandom_range(1) ? CLASS_ACK : CLASS_MON;
         id  = 8'($urandom_range(255));
         len = 16'($urandom_range(6));
      end else begin
         cls = 8'($urandom_range(255));
         id  = 8'($urandom_range(255));
         len = 16'($urandom_range(8));
      end
      if (hurt < 70) damage = INTACT;
      else if (hurt < 80) damage = BAD_CK_A;
      else if (hurt < 90) damage = BAD_CK_B;
      else damage = BAD_TAIL;
      send_frame(cls, id, len, 8'($urandom_range(255)), 8'($urandom_range(255)), damage);
   endtask

   // Line noise between frames. Noise bytes avoid both sync values, and a
   // first sync byte is always followed by a wrong second byte, so the parser
   // is back to hunting before the next frame begins.
   task automatic random_noise();
      logic [7:0] b;
      int         n;
      if ($urandom_range(1)) begin
         for (n = $urandom_range(6, 1); n > 0; n--) begin
            do b = 8'($urandom_range(255));
            while (b == SYNC_FIRST_BYTE || b == SYNC_SECOND_BYTE);
            send_byte(b);
         end
      end else begin
         send_byte(SYNC_FIRST_BYTE);
         do b = 8'($urandom_range(255)); while (b == SYNC_SECOND_BYTE);
         send_byte(b);
      end
   endtask

   initial begin
      int idle_pct [4];
      int stall_pct [4];
      int ph;
      int target;

      // Idling phases: none, sender idle, receiver stalling, both.
      idle_pct  = '{0, 73, 0, 37};
      stall_pct = '{0, 0, 73, 37};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames. A repeated first sync byte must drop the parser back
      // to hunting, not leave it waiting for the second byte, so the byte
      // after it is plain noise.
      send_byte(SYNC_FIRST_BYTE);
      send_byte(SYNC_FIRST_BYTE);
      send_byte(SYNC_SECOND_BYTE);
      // Acknowledge at its minimum length, with payload bytes at the extremes.
      send_frame(CLASS_ACK, ID_ACK_ACK, MIN_ACK_LENGTH, 8'hFF, 8'h00, INTACT);
      // Zero length: straight to the checksum, and too short to be classified.
      send_frame(CLASS_ACK, ID_ACK_NAK, 16'd0, 8'h00, 8'h00, INTACT);
      // Bad checksum on an otherwise valid negative acknowledge.
      send_frame(CLASS_ACK, ID_ACK_NAK, MIN_ACK_LENGTH, 8'h00, 8'hFF, BAD_CK_A);

      for (ph = 0; ph < 4; ph++) begin
         send_idle_pct  = idle_pct[ph];
         recv_stall_pct = stall_pct[ph];
         // One frame longer than 255 bytes uses the high length byte and runs
         // the payload count past its low byte; it is sent while nothing idles.
         if (ph == 0)
            send_frame(8'($urandom_range(255)), 8'($urandom_range(255)),
                       {8'h01, 8'($urandom_range(255))}, 8'($urandom_range(255)),
                       8'($urandom_range(255)), INTACT);
         target = bytes_sent + PHASE_BYTES;
         while (bytes_sent < target) begin
            if ($urandom_range(99) < 70) random_frame();
            else random_noise();
         end
      end

      req_valid <= 1'b0;

      // Let the count of owed results catch up with the last byte, wait until
      // every result has been taken, then give the block a few more cycles in
      // which any stray result would show up.
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (fail_count == 0) begin
         $display("ubx_frame_parser_tb: clean");
      end else begin
         $display("ubx_frame_parser_tb: errors");
      end
      $finish;
   end

endmodule
